[design/hefp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hefp_pkg
// Character codes, field limits and hex digit decoding for the event frame
// parser.
// ----------------------------------------------------------------------------
package hefp_pkg;

  localparam logic [7:0] START_CHAR = 8'h55;
  localparam logic [7:0] SEP_CHAR   = 8'h2C;
  localparam logic [7:0] END_CHAR   = 8'h0A;

  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] UPPER_A    = 8'd65;
  localparam logic [7:0] LOWER_A    = 8'd97;

  localparam logic [2:0] MAX_DIGITS = 3'd4;
  localparam logic [1:0] LAST_FIELD = 2'd3;
  localparam logic [8:0] CHECK_MOD  = 9'd255;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] t;
    d = '0;
    t = '0;
    if (c >= DIGIT_ZERO && c <= DIGIT_ZERO + 8'd9) begin
      t     = c - DIGIT_ZERO;
      d.ok  = 1'b1;
      d.val = t[3:0];
    end else if (c >= UPPER_A && c <= UPPER_A + 8'd5) begin
      t     = c - UPPER_A + 8'd10;
      d.ok  = 1'b1;
      d.val = t[3:0];
    end else if (c >= LOWER_A && c <= LOWER_A + 8'd5) begin
      t     = c - LOWER_A + 8'd10;
      d.ok  = 1'b1;
      d.val = t[3:0];
    end
    return d;
  endfunction

endpackage
`default_nettype wire

[design/hex_ascii_event_frame_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hex_ascii_event_frame_parser
// Finds "U,cc,ii,vvvv,ss\n" frames in a byte stream and emits checked events.
//
// Usage: received characters enter on rx_byte with rx_valid/rx_ready, one
// item per cycle while rx_ready is high. Events leave on command, event_index
// and event_value with event_valid/event_ready, one item for each well-formed
// frame whose checksum matches. Each byte is taken into an input register and
// parsed there by one pass of decode logic against the frame state; the event
// is written into the output register at the edge that retires its newline.
// Throughput is one byte per cycle, set by the single parse pass between input
// and output registers, apart from the stall below. When the receiver stalls,
// the output register holds the event and bytes that give no event keep
// flowing; only a second newline that yields an event waits in the input
// register, which then drops rx_ready.
// Reset (synchronous, active high) empties both registers and clears the
// frame state, so the stream is ignored until the next 'U'.
// ----------------------------------------------------------------------------
module hex_ascii_event_frame_parser
  import hefp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  output logic             rx_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             event_valid,
  input  wire logic        event_ready,
  output logic [7:0]       command,
  output logic [7:0]       event_index,
  output logic [15:0]      event_value
);

  logic        stage_valid;
  logic [7:0]  stage_byte;

  logic        in_frame, in_frame_next;
  logic        after_start, after_start_next;
  logic [1:0]  field_number, field_number_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [15:0] field_accumulator, field_accumulator_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_index, held_index_next;
  logic [15:0] held_value, held_value_next;
  logic        frame_bad, frame_bad_next;

  logic        emit;
  logic        advance;
  hex_digit_t  digit;
  logic [9:0]  byte_sum;
  logic [8:0]  fold;
  logic [8:0]  check;

  // checksum: fold the high bits since 256 mod 255 is 1
  always_comb begin
    byte_sum = {2'b00, held_command} + {2'b00, held_index}
             + {2'b00, held_value[7:0]} + {2'b00, held_value[15:8]};
    fold     = {7'd0, byte_sum[9:8]} + {1'b0, byte_sum[7:0]};
    check    = (fold >= CHECK_MOD) ? fold - CHECK_MOD : fold;
  end

  assign digit = hex_decode(stage_byte);

  always_comb begin
    in_frame_next          = in_frame;
    after_start_next       = after_start;
    field_number_next      = field_number;
    digit_count_next       = digit_count;
    field_accumulator_next = field_accumulator;
    held_command_next      = held_command;
    held_index_next        = held_index;
    held_value_next        = held_value;
    frame_bad_next         = frame_bad;
    emit                   = 1'b0;

    if (stage_byte == START_CHAR) begin
      in_frame_next          = 1'b1;
      after_start_next       = 1'b1;
      field_number_next      = '0;
      digit_count_next       = '0;
      field_accumulator_next = '0;
      held_command_next      = '0;
      held_index_next        = '0;
      held_value_next        = '0;
      frame_bad_next         = 1'b0;
    end else if (in_frame) begin
      if (stage_byte == END_CHAR) begin
        emit = !frame_bad && !after_start && field_number == LAST_FIELD
            && digit_count != 3'd0 && field_accumulator == {7'd0, check};
        in_frame_next          = 1'b0;
        after_start_next       = 1'b0;
        field_number_next      = '0;
        digit_count_next       = '0;
        field_accumulator_next = '0;
        held_command_next      = '0;
        held_index_next        = '0;
        held_value_next        = '0;
        frame_bad_next         = 1'b0;
      end else if (after_start) begin
        after_start_next = 1'b0;
        if (stage_byte != SEP_CHAR) begin
          frame_bad_next = 1'b1;
        end
      end else if (stage_byte == SEP_CHAR) begin
        if (digit_count == 3'd0 || field_number >= LAST_FIELD) begin
          frame_bad_next = 1'b1;
        end else begin
          case (field_number)
            2'd0:    held_command_next = field_accumulator[7:0];
            2'd1:    held_index_next   = field_accumulator[7:0];
            default: held_value_next   = field_accumulator;
          endcase
          field_number_next = field_number + 2'd1;
        end
        digit_count_next       = '0;
        field_accumulator_next = '0;
      end else if (!digit.ok || digit_count >= MAX_DIGITS) begin
        frame_bad_next = 1'b1;
      end else begin
        field_accumulator_next = {field_accumulator[11:0], digit.val};
        digit_count_next       = digit_count + 3'd1;
      end
    end
  end

  assign advance  = stage_valid && (!emit || !event_valid || event_ready);
  assign rx_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid       <= 1'b0;
      event_valid       <= 1'b0;
      in_frame          <= 1'b0;
      after_start       <= 1'b0;
      field_number      <= '0;
      digit_count       <= '0;
      field_accumulator <= '0;
      held_command      <= '0;
      held_index        <= '0;
      held_value        <= '0;
      frame_bad         <= 1'b0;
    end else begin
      if (rx_valid && rx_ready) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end

      if (advance) begin
        in_frame          <= in_frame_next;
        after_start       <= after_start_next;
        field_number      <= field_number_next;
        digit_count       <= digit_count_next;
        field_accumulator <= field_accumulator_next;
        held_command      <= held_command_next;
        held_index        <= held_index_next;
        held_value        <= held_value_next;
        frame_bad         <= frame_bad_next;
      end

      if (advance && emit) begin
        event_valid <= 1'b1;
      end else if (event_ready) begin
        event_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      stage_byte <= rx_byte;
    end
    if (advance && emit) begin
      command     <= held_command;
      event_index <= held_index;
      event_value <= held_value;
    end
  end

endmodule
`default_nettype wire

[test/hefp_event_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hefp_event_checker
// Watches the byte and event channels of the frame parser, keeps its own
// copy of the frame state, works out the event each accepted newline should
// give and compares every accepted event field by field in arrival order.
// ----------------------------------------------------------------------------
module hefp_event_checker
  import hefp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  input  wire logic        rx_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        event_valid,
  input  wire logic        event_ready,
  input  wire logic [7:0]  command,
  input  wire logic [7:0]  event_index,
  input  wire logic [15:0] event_value,
  output int               mismatches,
  output int               pending
);

  localparam logic [2:0] CMD_FIELD   = 3'd0;
  localparam logic [2:0] INDEX_FIELD = 3'd1;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  idx;
    logic [15:0] val;
  } frame_event_t;

  frame_event_t expected_events[$];

  logic        in_frame;
  logic        after_start;
  logic        frame_bad;
  logic [2:0]  field_no;
  logic [2:0]  digit_no;
  logic [15:0] field_acc;
  logic [7:0]  got_cmd;
  logic [7:0]  got_idx;
  logic [15:0] got_val;

  // {valid, nibble}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= DIGIT_ZERO && c < DIGIT_ZERO + 8'd10) return {1'b1, 4'(c - DIGIT_ZERO)};
    if (c >= UPPER_A && c < UPPER_A + 8'd6) return {1'b1, 4'(c - UPPER_A + 8'd10)};
    if (c >= LOWER_A && c < LOWER_A + 8'd6) return {1'b1, 4'(c - LOWER_A + 8'd10)};
    return 5'd0;
  endfunction

  task automatic clear_fields();
    after_start = 1'b0;
    frame_bad   = 1'b0;
    field_no    = '0;
    digit_no    = '0;
    field_acc   = '0;
    got_cmd     = '0;
    got_idx     = '0;
    got_val     = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [4:0]   nib;
    int           sum;
    frame_event_t ev;
    nib = nibble_of(b);
    sum = (int'(got_cmd) + int'(got_idx) + int'(got_val[7:0]) + int'(got_val[15:8]))
          % int'(CHECK_MOD);
    if (b == START_CHAR) begin
      clear_fields();
      in_frame    = 1'b1;
      after_start = 1'b1;
    end else if (in_frame) begin
      if (b == END_CHAR) begin
        if (!frame_bad && !after_start && field_no == 3'(LAST_FIELD) && digit_no != 0 &&
            int'(field_acc) == sum) begin
          ev.cmd = got_cmd;
          ev.idx = got_idx;
          ev.val = got_val;
          expected_events.push_back(ev);
        end
        in_frame = 1'b0;
        clear_fields();
      end else if (after_start) begin
        after_start = 1'b0;
        if (b != SEP_CHAR) frame_bad = 1'b1;
      end else if (b == SEP_CHAR) begin
        if (digit_no == 0 || field_no >= 3'(LAST_FIELD)) begin
          frame_bad = 1'b1;
        end else begin
          case (field_no)
            CMD_FIELD:   got_cmd = field_acc[7:0];
            INDEX_FIELD: got_idx = field_acc[7:0];
            default:     got_val = field_acc;
          endcase
          field_no = field_no + 3'd1;
        end
        digit_no  = '0;
        field_acc = '0;
      end else if (!nib[4] || digit_no >= MAX_DIGITS) begin
        frame_bad = 1'b1;
      end else begin
        field_acc = {field_acc[11:0], nib[3:0]};
        digit_no  = digit_no + 3'd1;
      end
    end
  endtask

  task automatic check_event();
    frame_event_t want;
    if (expected_events.size() == 0) begin
      $error("command: expected no item, got %0h", command);
      mismatches++;
    end else begin
      want = expected_events.pop_front();
      if (command !== want.cmd) begin
        $error("command: expected %0h, got %0h", want.cmd, command);
        mismatches++;
      end
      if (event_index !== want.idx) begin
        $error("event_index: expected %0h, got %0h", want.idx, event_index);
        mismatches++;
      end
      if (event_value !== want.val) begin
        $error("event_value: expected %0h, got %0h", want.val, event_value);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_frame = 1'b0;
      clear_fields();
      expected_events.delete();
      mismatches = 0;
    end else begin
      if (event_valid && event_ready) check_event();
      if (rx_valid && rx_ready) parse_byte(rx_byte);
    end
    pending = expected_events.size();
  end

endmodule
`default_nettype wire

[test/tb_hex_ascii_event_frame_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_hex_ascii_event_frame_parser
// Feeds the frame parser a byte stream of well-formed frames with random
// fields and digit counts, mixed with broken frames, restarts and line
// noise, under random idling on both sides and one long receiver hold-off.
// The checker beside the block predicts and compares; this top gives the
// verdict once every expected event has arrived or the drain limit runs out.
// ----------------------------------------------------------------------------
module tb_hex_ascii_event_frame_parser
  import hefp_pkg::*;
();

  localparam int         IDLE_PCT    = 27;
  localparam int         HOLD_CYCLES = 300;
  localparam int         HOLD_FRAME  = 35;
  localparam int         FRAME_COUNT = 42;
  localparam int         DRAIN_LIMIT = 5000;
  localparam logic [7:0] CR_CHAR     = 8'h0D;

  typedef enum int {
    GOOD, BAD_SUM, NO_COMMA, EMPTY_FIELD, LONG_FIELD,
    BAD_CHAR, EXTRA_FIELD, SHORT_FRAME, RESTART, NOISE
  } frame_kind_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        rx_valid    = 1'b0;
  logic [7:0]  rx_byte     = 8'd0;
  logic        event_ready = 1'b0;
  logic        rx_ready;
  logic        event_valid;
  logic [7:0]  command;
  logic [7:0]  event_index;
  logic [15:0] event_value;
  int          mismatches;
  int          pending;

  logic        calm     = 1'b0;
  logic        hold_req = 1'b0;
  logic [7:0]  frame_bytes[$];

  hex_ascii_event_frame_parser DUT (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_ready    (rx_ready),
    .rx_byte     (rx_byte),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .command     (command),
    .event_index (event_index),
    .event_value (event_value)
  );

  hefp_event_checker u_event_checker (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_ready    (rx_ready),
    .rx_byte     (rx_byte),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .command     (command),
    .event_index (event_index),
    .event_value (event_value),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= DIGIT_ZERO && c < DIGIT_ZERO + 8'd10) ||
           (c >= UPPER_A && c < UPPER_A + 8'd6) ||
           (c >= LOWER_A && c < LOWER_A + 8'd6);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return DIGIT_ZERO + 8'(n);
    if ($urandom_range(1)) return UPPER_A + 8'(n) - 8'd10;
    return LOWER_A + 8'(n) - 8'd10;
  endfunction

  function automatic int digits_for(input logic [15:0] v);
    if (v < 16'h10) return 1;
    if (v < 16'h100) return 2;
    if (v < 16'h1000) return 3;
    return 4;
  endfunction

  function automatic void push_field(input logic [15:0] v, input int nd);
    for (int i = nd - 1; i >= 0; i--) frame_bytes.push_back(hex_char(v[4*i +: 4]));
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  // anything a frame cannot hold: not hex, separator, newline or start
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    if ($urandom_range(1)) return CR_CHAR;
    do c = 8'($urandom_range(255));
    while (is_hex(c) || c == SEP_CHAR || c == END_CHAR || c == START_CHAR);
    return c;
  endfunction

  function automatic void build_frame(input frame_kind_t kind);
    logic [15:0] f[4];
    int          nd[4];
    int          sum;
    int          bad_pos;
    logic [7:0]  c;
    if (kind == NOISE) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    bad_pos = (kind == SHORT_FRAME) ? $urandom_range(0, 2) : $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      nd[i] = $urandom_range(1, 4);
      f[i]  = 16'($urandom) >> (4 * (4 - nd[i]));
    end
    sum = (int'(f[0][7:0]) + int'(f[1][7:0]) + int'(f[2][7:0]) + int'(f[2][15:8]))
          % int'(CHECK_MOD);
    f[3] = 16'(sum);
    if (kind == BAD_SUM) f[3] = 16'(sum + $urandom_range(1, 254));
    nd[3] = $urandom_range(4, digits_for(f[3]));
    // partial frame cut short by a fresh start
    if (kind == RESTART) begin
      frame_bytes.push_back(START_CHAR);
      frame_bytes.push_back(SEP_CHAR);
      push_field(16'($urandom), $urandom_range(1, 4));
      if ($urandom_range(1)) frame_bytes.push_back(SEP_CHAR);
    end
    frame_bytes.push_back(START_CHAR);
    if (kind == NO_COMMA) begin
      do c = 8'($urandom_range(255));
      while (c == SEP_CHAR);
      frame_bytes.push_back(c);
    end else begin
      frame_bytes.push_back(SEP_CHAR);
    end
    for (int i = 0; i < 4; i++) begin
      if (kind == LONG_FIELD && i == bad_pos) begin
        push_field(16'($urandom), 4);
        frame_bytes.push_back(hex_char(4'($urandom)));
      end else if (!(kind == EMPTY_FIELD && i == bad_pos)) begin
        push_field(f[i], nd[i]);
      end
      if (kind == BAD_CHAR && i == bad_pos) frame_bytes.push_back(junk_char());
      if (i < 3) begin
        if (kind == SHORT_FRAME && i == bad_pos) begin
          frame_bytes.push_back(END_CHAR);
          return;
        end
        frame_bytes.push_back(SEP_CHAR);
      end
    end
    if (kind == EXTRA_FIELD) begin
      frame_bytes.push_back(SEP_CHAR);
      push_field(16'($urandom), $urandom_range(1, 4));
    end
    frame_bytes.push_back(END_CHAR);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        rx_valid <= 1'b0;
        @(posedge clk);
      end
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  // receiver side: random stalls, a calm stretch, one long hold-off
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        event_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        event_ready <= 1'b1;
      end else begin
        event_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    frame_kind_t kind;
    int          waited;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // all-zero fields, then all-ones fields in mixed case
    push_text("U,0,0,0,0\n");
    push_text("U,ff,FF,FFff,0\n");
    send_frame();

    for (int n = 0; n < FRAME_COUNT; n++) begin
      calm = (n >= 15 && n < 25);
      if (n == HOLD_FRAME) hold_req = 1'b1;
      if (n >= HOLD_FRAME && n < HOLD_FRAME + 6) kind = GOOD;
      else if ($urandom_range(99) < 55) kind = GOOD;
      else kind = frame_kind_t'($urandom_range(1, 9));
      build_frame(kind);
      if ($urandom_range(3) == 0) build_frame(NOISE);
      send_frame();
    end
    rx_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
design/hefp_pkg.sv
design/hex_ascii_event_frame_parser.sv
test/hefp_event_checker.sv
test/tb_hex_ascii_event_frame_parser.sv
